[sv/command_frame_sync_hunter_unit_macros.svh]
// assertion macros for the command frame sync hunter unit
`ifndef COMMAND_FRAME_SYNC_HUNTER_UNIT_MACROS_SVH
`define COMMAND_FRAME_SYNC_HUNTER_UNIT_MACROS_SVH

// checked only while out of reset
`define CFSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CFSH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/cfsh_pkg.sv]
// types, constants and the checksum function of the command frame sync hunter
`default_nettype none

package cfsh_pkg;

  localparam int BYTE_W       = 8;
  localparam int FRAME_BYTES  = 4;
  localparam int DEVICE_SLOTS = 8;
  localparam int SLOT_COUNT   = 8;
  localparam int SLOT_IDX_W   = 3;
  localparam int CFG_IDX_W    = 4;
  localparam int SLOT_W       = 9;
  localparam int FILL_W       = 3;
  localparam int WIN_IDX_W    = 2;

  localparam logic [FILL_W-1:0]    FILL_FULL  = FILL_W'(FRAME_BYTES);
  localparam logic [CFG_IDX_W-1:0] SLOT_LIMIT = CFG_IDX_W'(SLOT_COUNT);
  localparam logic [BYTE_W:0]      CSUM_FOLD  = 9'd255;

  typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] window_t;

  typedef struct packed {
    logic              used;
    logic [BYTE_W-1:0] id;
  } slot_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [SLOT_W-1:0]    wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              restart_hunt;
  } in_t;

  typedef struct packed {
    logic              frame_found;
    logic [BYTE_W-1:0] target_id;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] aux_first;
    logic [BYTE_W-1:0] aux_second;
  } out_t;

  // 8-bit add with end-around carry over the frame bytes
  function automatic logic [BYTE_W-1:0] frame_sum(input window_t w);
    logic [BYTE_W:0] acc;
    acc = '0;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      acc = {1'b0, acc[BYTE_W-1:0]} + {1'b0, w[k]};
      if (acc > CSUM_FOLD) begin
        acc = acc - CSUM_FOLD;
      end
    end
    return acc[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/cfsh_in_if.sv]
// received byte channel
`default_nettype none

interface cfsh_in_if;
  logic          valid;
  logic          ready;
  cfsh_pkg::in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/cfsh_out_if.sv]
// frame result channel
`default_nettype none

interface cfsh_out_if;
  logic           valid;
  logic           ready;
  cfsh_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/cfsh_slot_match.sv]
// device slot registers and the active device identifier compare
`default_nettype none

module cfsh_slot_match (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cfsh_pkg::cfg_wr_t             cfg_i,
  input  wire logic [cfsh_pkg::BYTE_W-1:0]   probe_id_i,
  output logic                               hit_o
);

  cfsh_pkg::slot_t [cfsh_pkg::SLOT_COUNT-1:0] slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (cfg_i.we && (cfg_i.idx < cfsh_pkg::SLOT_LIMIT)) begin
      slot_q[cfg_i.idx[cfsh_pkg::SLOT_IDX_W-1:0]] <= cfsh_pkg::slot_t'(cfg_i.wdata);
    end
  end

  always_comb begin
    hit_o = 1'b0;
    for (int s = 0; s < cfsh_pkg::DEVICE_SLOTS; s++) begin
      if (slot_q[s].used && (slot_q[s].id == probe_id_i)) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/command_frame_sync_hunter_unit.sv]
// command frame sync hunter: four-byte window, device match and checksum check
// a byte moves from the input register into the result register, where its result waits to be taken
// throughput: one byte per cycle while results are taken; the window update closes within the cycle a byte leaves
// the input register, so back-to-back bytes never wait on each other
// reset: window emptied, device slots cleared to unused, both pipeline registers empty
`default_nettype none
`include "command_frame_sync_hunter_unit_macros.svh"

module command_frame_sync_hunter_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  cfsh_in_if.sink                               in_i,
  cfsh_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [cfsh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cfsh_pkg::SLOT_W-1:0]      cfg_wdata_i
);

  logic                              s1_valid_q, s1_valid_d;
  cfsh_pkg::in_t                     s1_q;
  logic                              out_valid_q, out_valid_d;
  cfsh_pkg::out_t                    out_q, out_d;
  cfsh_pkg::window_t                 win_q, win_d;
  logic [cfsh_pkg::FILL_W-1:0]       fill_q, fill_d;
  logic [cfsh_pkg::FILL_W-1:0]       fill_eff;
  logic                              in_ready, advance, s1_fire, in_fire;
  logic                              full, dev_hit, frame_hit;
  cfsh_pkg::cfg_wr_t                 cfg_wr;

  assign cfg_wr = '{we: cfg_we_i, idx: cfg_idx_i, wdata: cfg_wdata_i};

  cfsh_slot_match u_slot_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .probe_id_i (win_q[0]),
    .hit_o      (dev_hit)
  );

  // handshake: result register frees when empty or taken
  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || advance;
  assign s1_fire  = s1_valid_q && advance;
  assign in_fire  = in_i.valid && in_ready;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign fill_eff  = s1_q.restart_hunt ? '0 : fill_q;
  assign full      = (fill_eff == cfsh_pkg::FILL_FULL);
  assign frame_hit = full && dev_hit && (cfsh_pkg::frame_sum(win_q) == s1_q.rx_byte);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_eff;
    out_d  = '0;
    if (frame_hit) begin
      fill_d             = '0;
      out_d.frame_found  = 1'b1;
      out_d.target_id    = win_q[0];
      out_d.command_code = win_q[1];
      out_d.aux_first    = win_q[2];
      out_d.aux_second   = win_q[3];
    end else if (full) begin
      // slide by one byte
      for (int k = 0; k < cfsh_pkg::FRAME_BYTES - 1; k++) begin
        win_d[k] = win_q[k+1];
      end
      win_d[cfsh_pkg::FRAME_BYTES-1] = s1_q.rx_byte;
    end else begin
      win_d[fill_eff[cfsh_pkg::WIN_IDX_W-1:0]] = s1_q.rx_byte;
      fill_d = fill_eff + 3'd1;
    end
  end

  assign s1_valid_d  = in_ready ? in_i.valid : s1_valid_q;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.payload;
    end
    if (s1_fire) begin
      out_q <= out_d;
      win_q <= win_d;
    end
  end

  `CFSH_ASSERT_ALWAYS(a_fill_range, !rst_ni || (fill_q <= cfsh_pkg::FILL_FULL), "fill count beyond frame")
  `CFSH_ASSERT(a_hit_empties, s1_fire && frame_hit |=> fill_q == '0, "window kept after frame")
  `CFSH_ASSERT(a_append_grows, s1_fire && !frame_hit && !full |=> fill_q == $past(fill_eff) + 3'd1, "append did not grow window")
  `CFSH_ASSERT(a_miss_zero, out_valid_q && !out_q.frame_found |-> out_q.target_id == '0 && out_q.aux_second == '0, "no-frame result not cleared")
  `CFSH_ASSERT(a_hit_full, frame_hit |-> fill_eff == cfsh_pkg::FILL_FULL && dev_hit, "frame reported on partial window")

endmodule

`default_nettype wire

[tb/command_frame_sync_hunter_unit_checker.sv]
// frame result checker for the command frame sync hunter: tracks slots and window, compares results
`timescale 1ns / 100ps

module command_frame_sync_hunter_unit_checker
  import cfsh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cfsh_in_if                   in_mon_i,
  cfsh_out_if                  out_mon_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SLOT_W-1:0]    cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  slot_t             slot_cfg [SLOT_COUNT];
  logic [BYTE_W-1:0] held_bytes [FRAME_BYTES];
  int unsigned       held_count;
  out_t              frame_results_q [$];

  // add with end-around carry over the held bytes, oldest first
  function automatic logic [BYTE_W-1:0] end_around_sum();
    logic [BYTE_W:0] acc;
    acc = '0;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      acc = acc + held_bytes[k];
      if (acc > 9'd255) begin
        acc = acc - 9'd255;
      end
    end
    return acc[BYTE_W-1:0];
  endfunction

  function automatic bit id_enabled(input logic [BYTE_W-1:0] id);
    for (int s = 0; s < DEVICE_SLOTS; s++) begin
      if (slot_cfg[s].used && slot_cfg[s].id == id) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // one received byte: completes a frame, slides a full window or appends to a partial one
  function automatic void advance_hunt(input in_t item);
    out_t res;
    res = '0;
    if (item.restart_hunt) begin
      held_count = 0;
    end
    if (held_count >= FRAME_BYTES) begin
      if (id_enabled(held_bytes[0]) && end_around_sum() == item.rx_byte) begin
        res.frame_found  = 1'b1;
        res.target_id    = held_bytes[0];
        res.command_code = held_bytes[1];
        res.aux_first    = held_bytes[2];
        res.aux_second   = held_bytes[3];
        held_count = 0;
      end else begin
        for (int k = 0; k < FRAME_BYTES - 1; k++) begin
          held_bytes[k] = held_bytes[k + 1];
        end
        held_bytes[FRAME_BYTES-1] = item.rx_byte;
      end
    end else begin
      held_bytes[held_count] = item.rx_byte;
      held_count++;
    end
    frame_results_q.push_back(res);
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      foreach (slot_cfg[s]) slot_cfg[s] = '0;
      foreach (held_bytes[k]) held_bytes[k] = '0;
      held_count = 0;
      frame_results_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < SLOT_LIMIT) begin
        slot_cfg[cfg_idx_i] = cfg_wdata_i;
      end
      // check the outgoing transfer before queuing the incoming one
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = out_mon_i.payload;
        if (frame_results_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result: expected none, actual found=%0b id=%02h cmd=%02h aux=%02h/%02h",
                   $time, got.frame_found, got.target_id, got.command_code,
                   got.aux_first, got.aux_second);
        end else begin
          want = frame_results_q.pop_front();
          if (got.frame_found !== want.frame_found || got.target_id !== want.target_id ||
              got.command_code !== want.command_code || got.aux_first !== want.aux_first ||
              got.aux_second !== want.aux_second) begin
            errors_o++;
            $display("%0t: result mismatch: expected found=%0b id=%02h cmd=%02h aux=%02h/%02h",
                     $time, want.frame_found, want.target_id, want.command_code,
                     want.aux_first, want.aux_second);
            $display("%0t:                  actual   found=%0b id=%02h cmd=%02h aux=%02h/%02h",
                     $time, got.frame_found, got.target_id, got.command_code,
                     got.aux_first, got.aux_second);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        advance_hunt(in_mon_i.payload);
      end
    end
    pending_o = frame_results_q.size();
  end

endmodule

[tb/command_frame_sync_hunter_unit_tb.sv]
// stimulus, handshake pacing and verdict for the command frame sync hunter
`timescale 1ns / 100ps

module command_frame_sync_hunter_unit_tb;
  import cfsh_pkg::*;

  localparam int unsigned PHASES         = 5;
  localparam int unsigned PHASE_ITEMS    = 205;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SEND_IDLE [PHASES] = '{0, 83, 0, 21, 0};
  localparam int unsigned RECV_STALL[PHASES] = '{0, 0, 83, 21, 0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cfsh_in_if  in_ch ();
  cfsh_out_if out_ch ();

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SLOT_W-1:0]    cfg_wdata;

  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  logic              hold_req;
  logic [SLOT_W-1:0] slot_image [SLOT_COUNT];
  int                errors;
  int                pending;
  int unsigned       quiet_cycles;

  always #5 clk_i = ~clk_i;

  command_frame_sync_hunter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  command_frame_sync_hunter_unit_checker u_frame_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // closed form of the end-around add: zero only for an all-zero frame
  function automatic logic [BYTE_W-1:0] folded_sum(input logic [BYTE_W-1:0] b0, b1, b2, b3);
    int unsigned total;
    total = b0 + b1 + b2 + b3;
    return (total == 0) ? 8'h00 : 8'((total - 1) % 255 + 1);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid                <= 1'b1;
    in_ch.payload.rx_byte      <= rx;
    in_ch.payload.restart_hunt <= restart;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] id, cmd, a1, a2,
                            input bit restart_first, input bit corrupt);
    logic [BYTE_W-1:0] check;
    check = folded_sum(id, cmd, a1, a2);
    if (corrupt) begin
      check = check ^ 8'($urandom_range(255, 1));
    end
    send_byte(id, restart_first);
    send_byte(cmd, 1'b0);
    send_byte(a1, 1'b0);
    send_byte(a2, 1'b0);
    send_byte(check, 1'b0);
  endtask

  // stop offering, then wait until every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // all slots from slot_image, then one write that lands past the last slot
  task automatic load_slots(input logic [SLOT_W-1:0] junk);
    for (int s = 0; s < SLOT_COUNT; s++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(s);
      cfg_wdata <= slot_image[s];
      @(posedge clk_i);
    end
    cfg_idx   <= CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, SLOT_COUNT));
    cfg_wdata <= junk;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver pacing, with one long hold-off counted here
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] ids [$];
    logic [BYTE_W-1:0] frame_id;
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       runs;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset slots are all unused: the window fills and slides, nothing matches
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    drain();
    slot_image = '{9'h100, 9'h0CD, 9'h155, 9'h000, 9'h000, 9'h07E, 9'h000, 9'h1FF};
    load_slots(9'h1AB);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);  // all-zero frame, zero checksum
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);  // checksum wraps to 255
    send_frame(8'hCD, 8'h12, 8'h34, 8'h56, 1'b1, 1'b0);  // id sits in a slot marked unused
    send_frame(8'hAB, 8'h80, 8'h01, 8'h7F, 1'b1, 1'b0);  // id only written past the last slot

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      foreach (slot_image[s]) begin
        case (ph)
          1:       slot_image[s] = 9'h1FF;
          3:       slot_image[s] = 9'h000;
          default: slot_image[s] = {1'($urandom_range(1)), 8'($urandom)};
        endcase
      end
      load_slots(SLOT_W'($urandom));
      ids.delete();
      foreach (slot_image[s]) begin
        if (slot_image[s][BYTE_W]) ids.push_back(slot_image[s][BYTE_W-1:0]);
      end
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      if (ph == PHASES - 1) begin
        hold_req <= 1'b1;
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(9);
        frame_id = (ids.size() != 0) ? ids[$urandom_range(ids.size() - 1)] : 8'($urandom);
        if (pick < 6) begin
          send_frame(frame_id, 8'($urandom), 8'($urandom), 8'($urandom),
                     ($urandom_range(3) == 0), 1'b0);
          sent += 5;
        end else if (pick == 6) begin
          send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     ($urandom_range(1) == 0), 1'b0);
          sent += 5;
        end else if (pick == 7) begin
          send_frame(frame_id, 8'($urandom), 8'($urandom), 8'($urandom),
                     ($urandom_range(3) == 0), 1'b1);
          sent += 5;
        end else begin
          runs = $urandom_range(3, 1);
          repeat (runs) send_byte(8'($urandom), ($urandom_range(7) == 0));
          sent += runs;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/cfsh_pkg.sv
sv/cfsh_in_if.sv
sv/cfsh_out_if.sv
sv/cfsh_slot_match.sv
sv/command_frame_sync_hunter_unit.sv
tb/command_frame_sync_hunter_unit_checker.sv
tb/command_frame_sync_hunter_unit_tb.sv
